// ===== hw/rtl/clsue_pkg.sv =====
// Shared types, constants and lookup functions of the character LCD update engine.
package clsue_pkg;

    // Screen geometry
    localparam int ROWS         = 4;
    localparam int COLS         = 20;
    localparam int SHADOW_DEPTH = ROWS * COLS;
    localparam int ADDR_W       = $clog2(SHADOW_DEPTH);

    // Step counter covers the longest sequence (initialize, 24 words)
    localparam int MAX_WORDS = 24;
    localparam int STEP_W    = $clog2(MAX_WORDS + 1);

    // Word counts per operation
    localparam logic [STEP_W-1:0] CNT_NONE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] CNT_CHAR  = STEP_W'(8);
    localparam logic [STEP_W-1:0] CNT_CLEAR = STEP_W'(4);
    localparam logic [STEP_W-1:0] CNT_LIGHT = STEP_W'(1);
    localparam logic [STEP_W-1:0] CNT_INIT  = STEP_W'(MAX_WORDS);

    // Number of bare init nibble words before the command bytes
    localparam logic [STEP_W-1:0] INIT_NIB_WORDS = STEP_W'(8);

    // LCD byte codes
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_WAKE_8BIT = 8'h30;
    localparam logic [7:0] LCD_WAKE_4BIT = 8'h20;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] SPACE_CHAR    = 8'h20;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LIGHT = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE_MASK    = 2'd0;
    localparam logic [1:0] CFG_BACKLIGHT_MASK = 2'd1;
    localparam logic [1:0] CFG_DATA_SEL_MASK  = 2'd2;
    localparam logic [1:0] CFG_CMD_SEL_MASK   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              commit;
        logic              emit;
        logic              last;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [STEP_W-1:0] count;
        logic [STEP_W-1:0] count_held;
    } t_dp_status;

    // DDRAM start address of each row
    function automatic logic [7:0] row_start(input logic [1:0] row);
        logic [7:0] addr;
        unique case (row)
            2'd0:    addr = 8'h00;
            2'd1:    addr = 8'h40;
            2'd2:    addr = 8'h14;
            default: addr = 8'h54;
        endcase
        return addr;
    endfunction

    // Command bytes sent after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = LCD_FUNC_SET;
            2'd1:    b = LCD_DISP_ON;
            2'd2:    b = LCD_CLEAR;
            default: b = LCD_ENTRY;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_shadow_update_engine.sv =====
// Top level: character LCD shadow update engine for a 4-bit LCD behind a port expander.
//
// Usage: drive i_operation, i_row, i_column, i_character and i_light_on and
// raise i_start; the command word is taken at a rising edge where i_start is
// high and o_busy is low. The block answers with a stream of expander words on
// o_expander_byte, each shown for one cycle with o_valid high; o_last_byte
// marks the final word of the command. The receiver cannot stall the stream,
// so it must take every word on the cycle it appears.
// Timing: after accept, the controller reads the screen shadow memory in
// S_READ, then decides and commits in S_DECIDE; words then follow one per
// cycle from the output register, and o_busy stays high through the last
// emit step. A command's word count is 8 for a changed character, 0 for
// an unchanged or off-screen one, 4 for clear, 1 for backlight, 24 for
// initialize. The step sequencer emitting one word per cycle sets this rate.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once
// and belong in idle periods. Reset restores the register defaults, turns the
// backlight flag on and marks the whole shadow as spaces through per-entry
// valid bits, so no clearing pass is needed.
module char_lcd_shadow_update_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_row,
    input  logic [4:0] i_column,
    input  logic [7:0] i_character,
    input  logic       i_light_on,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    output logic [7:0] o_expander_byte,
    output logic       o_last_byte
);

    clsue_pkg::t_dp_cmd    dp_cmd;
    clsue_pkg::t_dp_status dp_status;

    // Sequence each command
    clsue_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Hold shadow, configuration and output word
    clsue_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_operation     (i_operation),
        .i_row           (i_row),
        .i_column        (i_column),
        .i_character     (i_character),
        .i_light_on      (i_light_on),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_expander_byte (o_expander_byte),
        .o_last_byte     (o_last_byte)
    );

endmodule

// ===== hw/rtl/clsue_dp.sv =====
// Datapath: configuration, screen shadow memory, expander word generation.
module clsue_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  clsue_pkg::t_dp_cmd    i_cmd,
    output clsue_pkg::t_dp_status o_status,
    input  logic [1:0]            i_operation,
    input  logic [2:0]            i_row,
    input  logic [4:0]            i_column,
    input  logic [7:0]            i_character,
    input  logic                  i_light_on,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    output logic                  o_valid,
    output logic [7:0]            o_expander_byte,
    output logic                  o_last_byte
);

    localparam int AW = clsue_pkg::ADDR_W;
    localparam int SW = clsue_pkg::STEP_W;

    // Configuration registers
    logic [7:0] r_enable_mask;
    logic [7:0] r_backlight_mask;
    logic [3:0] r_data_sel_mask;
    logic [3:0] r_cmd_sel_mask;
    logic       r_light_state;

    // Captured command word
    clsue_pkg::t_op r_op;
    logic [2:0]     r_row;
    logic [4:0]     r_col;
    logic [7:0]     r_char;
    logic           r_light_on;

    // Shadow memory with per-entry valid bits
    logic [7:0]                        r_shadow [clsue_pkg::SHADOW_DEPTH];
    logic [clsue_pkg::SHADOW_DEPTH-1:0] r_shadow_valid;
    logic [7:0]                        r_rd_data;
    logic                              r_rd_valid;

    logic [SW-1:0] r_count;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic          in_range;
    logic [AW-1:0] idx;
    logic [AW-1:0] rd_addr;
    logic [7:0]    shadow_char;
    logic          changed;
    logic [SW-1:0] count;
    logic [7:0]    cursor_cmd;
    logic [SW-1:0] init_off;
    logic [7:0]    lcd_byte;
    logic [3:0]    sel;
    logic          nib_lo;
    logic          phase_low;
    logic          raw_word;
    logic [7:0]    raw_byte;
    logic [7:0]    nib_val;
    logic [7:0]    bl_bits;
    logic [7:0]    word;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask    <= 8'd4;
            r_backlight_mask <= 8'd8;
            r_data_sel_mask  <= 4'd1;
            r_cmd_sel_mask   <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clsue_pkg::CFG_ENABLE_MASK:    r_enable_mask    <= i_cfg_data;
                clsue_pkg::CFG_BACKLIGHT_MASK: r_backlight_mask <= i_cfg_data;
                clsue_pkg::CFG_DATA_SEL_MASK:  r_data_sel_mask  <= i_cfg_data[3:0];
                default:                       r_cmd_sel_mask   <= i_cfg_data[3:0];
            endcase
        end
    end

    // Capture the command word on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= clsue_pkg::t_op'(i_operation);
            r_row      <= i_row;
            r_col      <= i_column;
            r_char     <= i_character;
            r_light_on <= i_light_on;
        end
    end

    // Locate the shadow entry
    always_comb begin
        in_range = (r_row < 3'(clsue_pkg::ROWS)) && (r_col < 5'(clsue_pkg::COLS));
        idx      = AW'(r_row[1:0]) * AW'(clsue_pkg::COLS) + AW'(r_col);
        rd_addr  = in_range ? idx : '0;
    end

    // Read the shadow every cycle, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_shadow[rd_addr];
    end

    // Write the shadow on a changed character
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == clsue_pkg::OP_CHAR && changed) begin
            r_shadow[rd_addr] <= r_char;
        end
    end

    // Track valid bits, backlight state and held count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow_valid <= '0;
            r_rd_valid     <= 1'b0;
            r_light_state  <= 1'b1;
            r_count        <= clsue_pkg::CNT_NONE;
        end else begin
            r_rd_valid <= r_shadow_valid[rd_addr];
            if (i_cmd.commit) begin
                r_count <= count;
                case (r_op)
                    clsue_pkg::OP_CHAR: begin
                        if (changed) begin
                            r_shadow_valid[rd_addr] <= 1'b1;
                        end
                    end
                    clsue_pkg::OP_LIGHT: r_light_state <= r_light_on;
                    default:             r_shadow_valid <= '0;
                endcase
            end
        end
    end

    // Decide how many words this command produces
    always_comb begin
        shadow_char = r_rd_valid ? r_rd_data : clsue_pkg::SPACE_CHAR;
        changed     = in_range && (shadow_char != r_char);
        case (r_op)
            clsue_pkg::OP_CHAR:  count = changed ? clsue_pkg::CNT_CHAR : clsue_pkg::CNT_NONE;
            clsue_pkg::OP_CLEAR: count = clsue_pkg::CNT_CLEAR;
            clsue_pkg::OP_LIGHT: count = clsue_pkg::CNT_LIGHT;
            default:             count = clsue_pkg::CNT_INIT;
        endcase
    end

    assign o_status.count      = count;
    assign o_status.count_held = r_count;

    // Pick LCD byte, nibble and strobe phase for the current step
    always_comb begin
        cursor_cmd = clsue_pkg::LCD_SET_DDRAM
                   | (8'(r_col) + clsue_pkg::row_start(r_row[1:0]));
        init_off   = i_cmd.step - clsue_pkg::INIT_NIB_WORDS;
        lcd_byte   = clsue_pkg::LCD_CLEAR;
        sel        = r_cmd_sel_mask;
        nib_lo     = i_cmd.step[1];
        phase_low  = i_cmd.step[0];
        raw_word   = 1'b0;
        raw_byte   = r_light_on ? r_backlight_mask : 8'h00;
        case (r_op)
            clsue_pkg::OP_CHAR: begin
                lcd_byte = i_cmd.step[2] ? r_char : cursor_cmd;
                sel      = i_cmd.step[2] ? r_data_sel_mask : r_cmd_sel_mask;
            end
            clsue_pkg::OP_CLEAR: begin
                lcd_byte = clsue_pkg::LCD_CLEAR;
            end
            clsue_pkg::OP_LIGHT: begin
                raw_word = 1'b1;
            end
            default: begin
                if (i_cmd.step < clsue_pkg::INIT_NIB_WORDS) begin
                    lcd_byte = (i_cmd.step[2:1] == 2'd3) ? clsue_pkg::LCD_WAKE_4BIT
                                                         : clsue_pkg::LCD_WAKE_8BIT;
                    sel      = 4'd0;
                    nib_lo   = 1'b0;
                end else begin
                    lcd_byte  = clsue_pkg::init_byte(init_off[3:2]);
                    nib_lo    = init_off[1];
                    phase_low = init_off[0];
                end
            end
        endcase
    end

    // Form the expander word
    always_comb begin
        nib_val = {(nib_lo ? lcd_byte[3:0] : lcd_byte[7:4]), sel};
        bl_bits = r_light_state ? r_backlight_mask : 8'h00;
        if (raw_word) begin
            word = raw_byte;
        end else if (phase_low) begin
            word = (nib_val & ~r_enable_mask) | bl_bits;
        end else begin
            word = nib_val | r_enable_mask | bl_bits;
        end
    end

    // Register the outgoing word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= word;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_expander_byte = r_out_byte;
    assign o_last_byte     = r_out_last;

endmodule

// ===== hw/rtl/clsue_ctrl.sv =====
// Controller: sequences shadow lookup, commit and word emission.
module clsue_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  clsue_pkg::t_dp_status i_status,
    output clsue_pkg::t_dp_cmd    o_cmd
);

    localparam int SW = clsue_pkg::STEP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [SW-1:0] r_step;
    logic [SW-1:0] n_step;
    logic          last;

    assign last = (r_step == i_status.count_held - SW'(1));

    // Decode next state and commands
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.last    = 1'b0;
        o_cmd.step    = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.commit = 1'b1;
                n_step       = '0;
                n_state      = (i_status.count == clsue_pkg::CNT_NONE) ? S_IDLE : S_EMIT;
            end
            default: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = last;
                if (last) begin
                    n_state = S_IDLE;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
        endcase
    end

    // Hold state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
